[hw/rtl/crcfa_pkg.sv]
// Shared types, constants and the byte-wide CRC-32 update for the frame CRC appender.
package crcfa_pkg;

    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

    // Output phase of one queued request: the frame byte, then CRC bytes 0..3.
    localparam logic [2:0] PHASE_DATA = 3'd0;
    localparam logic [2:0] PHASE_CRC0 = 3'd1;
    localparam logic [2:0] PHASE_CRC1 = 3'd2;
    localparam logic [2:0] PHASE_CRC2 = 3'd3;
    localparam logic [2:0] PHASE_CRC3 = 3'd4;

    typedef struct packed {
        logic [7:0]  data;
        logic        frame_end;
        logic [31:0] crc;      // final CRC, valid only when frame_end is set
    } crcfa_entry_t;

    // Reflected CRC-32, one byte, LSB first.
    function automatic logic [31:0] crc_update_byte(input logic [31:0] crc_in,
                                                    input logic [7:0]  byte_in);
        logic [31:0] c;
        logic        fb;
        c = crc_in;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ byte_in[k];
            c  = {1'b0, c[31:1]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/crc32_frame_appender.sv]
// An accepted byte goes through the queue, then the back end's hold register, onto m_.
// Throughput: 1 byte per cycle, stalled by a full queue or low m_ready; a frame end adds four
// CRC output bytes, absorbed by the QUEUE_DEPTH-entry queue while the input keeps streaming.
// The sustained input rate is set by the back end's single output port (bytes + 4 per frame).
// Reset (aresetn, sync, active low): remainder to all ones, queue empty, no output held.
module crc32_frame_appender import crcfa_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_frame_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_crc,
    output logic       m_out_last
);

    // front -> queue
    logic         push;
    crcfa_entry_t push_entry;
    logic         queue_full;

    // queue -> back
    logic         pop;
    logic         head_valid;
    crcfa_entry_t head_entry;

    // Front: CRC update per accepted request; the final CRC rides along in the
    // queue entry of the frame's last byte, so the remainder reloads at once.
    crcfa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data_byte(s_data_byte),
        .s_frame_end(s_frame_end),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    crcfa_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Back: holds one request in registers and drives m_ from them; next request
    // is loaded in the same cycle the current one's last byte is taken.
    crcfa_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_is_crc   (m_is_crc),
        .m_out_last (m_out_last)
    );

endmodule

[hw/rtl/crcfa_front.sv]
// Front end: accepts frame bytes, runs the CRC and builds queue entries.
module crcfa_front import crcfa_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_data_byte,
    input  logic         s_frame_end,
    output logic         push,
    output crcfa_entry_t push_entry,
    input  logic         queue_full
);

    logic [31:0] remainder_reg;
    logic [31:0] remainder_next;
    logic [31:0] crc_upd;

    assign crc_upd = crc_update_byte(remainder_reg, s_data_byte);
    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    assign push_entry.data      = s_data_byte;
    assign push_entry.frame_end = s_frame_end;
    assign push_entry.crc       = crc_upd ^ CRC_XOROUT;

    always_comb begin
        remainder_next = remainder_reg;
        if (push) begin
            remainder_next = s_frame_end ? CRC_INIT : crc_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remainder_reg <= CRC_INIT;
        end else begin
            remainder_reg <= remainder_next;
        end
    end

endmodule

[hw/rtl/crcfa_queue.sv]
// Small flip-flop FIFO between the front and back ends.
module crcfa_queue import crcfa_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  crcfa_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output crcfa_entry_t head_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    crcfa_entry_t    slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |-> !pop) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT) else $error("queue count out of range");
`endif

endmodule

[hw/rtl/crcfa_back.sv]
// Back end: plays out each queued byte and, at frame end, the four CRC bytes.
module crcfa_back import crcfa_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         head_valid,
    input  crcfa_entry_t head_entry,
    output logic         pop,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_out_byte,
    output logic         m_is_crc,
    output logic         m_out_last
);

    logic         hold_valid_reg, hold_valid_next;
    crcfa_entry_t hold_reg, hold_next;
    logic [2:0]   phase_reg, phase_next;
    logic         done;

    // request finishes when its last output byte is taken
    assign done = hold_valid_reg && m_ready &&
                  ((phase_reg == PHASE_CRC3) ||
                   ((phase_reg == PHASE_DATA) && !hold_reg.frame_end));
    assign pop  = head_valid && (!hold_valid_reg || done);

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        phase_next      = phase_reg;
        if (pop) begin
            hold_valid_next = 1'b1;
            hold_next       = head_entry;
            phase_next      = PHASE_DATA;
        end else if (done) begin
            hold_valid_next = 1'b0;
            phase_next      = PHASE_DATA;
        end else if (hold_valid_reg && m_ready) begin
            phase_next = phase_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= PHASE_DATA;
        end else begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
    end

    always_comb begin
        case (phase_reg)
            PHASE_DATA: m_out_byte = hold_reg.data;
            PHASE_CRC0: m_out_byte = hold_reg.crc[7:0];
            PHASE_CRC1: m_out_byte = hold_reg.crc[15:8];
            PHASE_CRC2: m_out_byte = hold_reg.crc[23:16];
            PHASE_CRC3: m_out_byte = hold_reg.crc[31:24];
            default:    m_out_byte = hold_reg.data;
        endcase
    end

    assign m_valid    = hold_valid_reg;
    assign m_is_crc   = (phase_reg != PHASE_DATA);
    assign m_out_last = (phase_reg == PHASE_CRC3);

`ifndef SYNTH
    a_crc_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_valid_reg && phase_reg != PHASE_DATA) |-> hold_reg.frame_end)
        else $error("CRC phase on a non-final byte");
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PHASE_CRC3) else $error("phase out of range");
    a_last_resets_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_out_last) |=> (phase_reg == PHASE_DATA))
        else $error("phase not restarted after last CRC byte");
`endif

endmodule

[tb/crcfa_checker.sv]
// Scoreboard for the frame CRC appender: predicts each output byte and compares it.
`timescale 1ns / 100ps

module crcfa_checker import crcfa_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_frame_end,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_is_crc,
    input  logic       m_out_last,
    output int         fail_count,
    output int         bytes_due
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_crc;
        logic       out_last;
    } out_byte_t;

    out_byte_t   bytes_due_q[$];
    logic [31:0] crc_acc;

    // Reflected CRC-32, data LSB first.
    function automatic logic [31:0] crc_advance(input logic [31:0] acc, input logic [7:0] d);
        logic [31:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ d[i]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // Queue the pass-through byte and, on a frame end, the four CRC bytes.
    task automatic predict_request(input logic [7:0] d, input logic fend);
        logic [31:0] fcs;
        out_byte_t   item;
        item = '{out_byte: d, is_crc: 1'b0, out_last: 1'b0};
        bytes_due_q = {bytes_due_q, item};
        crc_acc = crc_advance(crc_acc, d);
        if (fend) begin
            fcs = crc_acc ^ CRC_XOROUT;
            for (int i = 0; i < 4; i++) begin
                item = '{out_byte: fcs[8*i +: 8], is_crc: 1'b1, out_last: (i == 3)};
                bytes_due_q = {bytes_due_q, item};
            end
            crc_acc = CRC_INIT;
        end
    endtask

    always @(posedge aclk) begin
        out_byte_t want;
        if (!aresetn) begin
            crc_acc    = CRC_INIT;
            fail_count = 0;
            bytes_due_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                predict_request(s_data_byte, s_frame_end);
            end
            if (m_valid && m_ready) begin
                if (bytes_due_q.size() == 0) begin
                    $display("%0t: unexpected output byte=%h is_crc=%b last=%b",
                             $time, m_out_byte, m_is_crc, m_out_last);
                    fail_count++;
                end else begin
                    want = bytes_due_q.pop_front();
                    if (m_out_byte !== want.out_byte || m_is_crc !== want.is_crc ||
                        m_out_last !== want.out_last) begin
                        $display({"%0t: expected byte=%h is_crc=%b last=%b, ",
                                  "got byte=%h is_crc=%b last=%b"},
                                 $time, want.out_byte, want.is_crc, want.out_last,
                                 m_out_byte, m_is_crc, m_out_last);
                        fail_count++;
                    end
                end
            end
        end
        bytes_due = bytes_due_q.size();
    end

endmodule

[tb/tb_crc32_frame_appender.sv]
// Top testbench for the frame CRC appender: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_crc32_frame_appender;

    localparam int RESET_CYCLES      = 7;
    localparam int SINK_STALL_CYCLES = 80;      // long m_ready hold-off
    localparam int DRAIN_CYCLES      = 20;      // settle time after the last byte
    localparam int RUN_LIMIT_NS      = 5_000_000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_frame_end;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_is_crc;
    logic       m_out_last;

    int fail_count;
    int bytes_due;

    // Handshake flags between the stimulus and the result sink.
    bit sink_stall_req;
    bit sink_no_idle;

    crc32_frame_appender uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_frame_end (s_frame_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_is_crc    (m_is_crc),
        .m_out_last  (m_out_last)
    );

    crcfa_checker scoreboard (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_frame_end (s_frame_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_is_crc    (m_is_crc),
        .m_out_last  (m_out_last),
        .fail_count  (fail_count),
        .bytes_due   (bytes_due)
    );

    // 20 ns clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Hard stop in case the handshake hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    // Idle length: mostly a few cycles, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(8, 25);
        end
        return $urandom_range(1, 3);
    endfunction

    // Sender gap: zero about half the time so back-to-back requests are common.
    function automatic int sender_gap();
        if ($urandom_range(0, 1) == 0) begin
            return 0;
        end
        return pick_gap();
    endfunction

    // Offer one request at the falling edge and hold it until accepted.
    // A nonzero gap drops valid at the next falling edge for the length of the gap;
    // with gap zero, valid stays high into the next request.
    task automatic send_byte(input logic [7:0] d, input logic fend, input int gap);
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_data_byte <= d;
        s_frame_end <= fend;
        do @(posedge aclk); while (!s_ready);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // One frame of random bytes; the last one carries the frame end.
    task automatic send_frame(input int len, input bit gaps_on);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), (i == len - 1), gaps_on ? sender_gap() : 0);
        end
    endtask

    // Random frame length: mostly short, sometimes long.
    function automatic int pick_frame_len();
        if ($urandom_range(0, 5) == 0) begin
            return $urandom_range(9, 40);
        end
        return $urandom_range(1, 8);
    endfunction

    // Drop valid and hold off until every predicted byte has come out.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (bytes_due == 0);
    endtask

    // Result sink: random m_ready, one long stall on request, or always ready.
    initial begin : result_sink
        int hold;
        bit stall_done;
        m_ready    = 1'b0;
        stall_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (sink_stall_req && !stall_done) begin
                // long hold-off, counted here so the sender keeps pushing
                m_ready <= 1'b0;
                repeat (SINK_STALL_CYCLES - 1) @(negedge aclk);
                stall_done = 1'b1;
            end else if (sink_no_idle || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                hold = $urandom_range(0, 5);
                repeat (hold) @(negedge aclk);
            end else begin
                m_ready <= 1'b0;
                hold = pick_gap();
                repeat (hold - 1) @(negedge aclk);
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        logic [7:0] check_str [9];
        int n_sent;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data_byte    = 8'h00;
        s_frame_end    = 1'b0;
        sink_stall_req = 1'b0;
        sink_no_idle   = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed part ---
        // standard check string "123456789", CRC 0xCBF43926
        check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        foreach (check_str[i]) begin
            send_byte(check_str[i], (i == 8), sender_gap());
        end
        // single-byte frames at both extremes, back to back
        send_byte(8'h00, 1'b1, 0);
        send_byte(8'hFF, 1'b1, 0);
        // all-ones frame right after a frame end, remainder must be reloaded
        for (int i = 0; i < 4; i++) begin
            send_byte(8'hFF, (i == 3), sender_gap());
        end
        // mixed pattern: zero, top bit, low bit, all but the top bit, alternating bits
        send_byte(8'h00, 1'b0, 0);
        send_byte(8'h80, 1'b0, 0);
        send_byte(8'h01, 1'b0, 1);
        send_byte(8'h7F, 1'b0, 0);
        send_byte(8'hAA, 1'b0, 2);
        send_byte(8'h55, 1'b1, 0);

        // sender pauses until the block has emptied
        wait_drained();

        // --- random frames with gaps on both sides ---
        n_sent = 0;
        while (n_sent < 80) begin
            int len;
            len = pick_frame_len();
            send_frame(len, 1'b1);
            n_sent += len;
        end

        // --- sink stalls long while the sender streams, block backs up ---
        sink_stall_req = 1'b1;
        n_sent = 0;
        while (n_sent < 30) begin
            int len;
            len = $urandom_range(1, 6);
            send_frame(len, 1'b0);
            n_sent += len;
        end

        // --- full rate on both sides, no idle cycles ---
        sink_no_idle = 1'b1;
        n_sent = 0;
        while (n_sent < 35) begin
            int len;
            len = pick_frame_len();
            send_frame(len, 1'b0);
            n_sent += len;
        end
        wait_drained();
        sink_no_idle = 1'b0;

        // --- more random frames ---
        n_sent = 0;
        while (n_sent < 40) begin
            int len;
            len = pick_frame_len();
            send_frame(len, 1'b1);
            n_sent += len;
        end

        // let everything come out, then a few more cycles for strays
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && bytes_due == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/crcfa_pkg.sv
hw/rtl/crcfa_front.sv
hw/rtl/crcfa_queue.sv
hw/rtl/crcfa_back.sv
hw/rtl/crc32_frame_appender.sv
tb/crcfa_checker.sv
tb/tb_crc32_frame_appender.sv
